// ----- rtl/core/pee_pkg.sv -----
// shared types and constants for the postfix expression evaluator
package pee_pkg;

    // ascii codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_CARET = 8'h5E;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    // shared unit operations
    localparam logic [1:0] ALU_MUL = 2'd0;
    localparam logic [1:0] ALU_DIV = 2'd1;
    localparam logic [1:0] ALU_POW = 2'd2;

    // multiplier digit width, one digit of the right operand per cycle
    localparam int MUL_DIGIT = 16;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_cmd_t;

endpackage

// ----- rtl/core/pee_ifs.sv -----
// item channel interfaces for the postfix expression evaluator
interface pee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_expression;

    modport source (output valid, output character, output end_of_expression, input ready);
    modport sink   (input valid, input character, input end_of_expression, output ready);
endinterface

interface pee_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic [2:0]        status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- rtl/core/postfix_expression_evaluator.sv -----
// postfix expression evaluator top level: sequencer, operand stack and shared arithmetic unit
//
//   channel  | direction | payload                              | accepted when
//   ---------+-----------+--------------------------------------+--------------
//   expr     | in        | character[7:0], end_of_expression    | valid & ready
//   result   | out       | value[31:0] signed, status[2:0]      | valid & ready
//
// a digit is pushed at once; when it ends the expression the top of stack is read back as the result
// + and - are computed in the sequencer, * and / in pee_alu; a last operator then loads the result
// ^ is computed by square-and-multiply in pee_alu
// the multiplier in pee_alu does one 16-bit digit of the right operand per cycle
// reset clears the stack count, overflow flag and output valid; the stack memory is not cleared
// a result waits in the output register; a following result stalls until it is taken
module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int WORD_WIDTH  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pee_in_if.sink     expr,
    pee_out_if.source  result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RDTOP   = 3'd1;
    localparam logic [2:0] S_TOPWAIT = 3'd2;
    localparam logic [2:0] S_OPER    = 3'd3;
    localparam logic [2:0] S_ALU     = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [7:0]            op_reg, op_next;
    logic                  last_reg, last_next;
    logic [WORD_WIDTH-1:0] res_value_reg, res_value_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_value_reg, out_value_next;
    logic [2:0]            out_status_reg, out_status_next;

    // stack memory port signals
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic [CW-1:0]         count_m1;
    logic [CW-1:0]         count_m2;
    logic [WORD_WIDTH-1:0] rd_a;
    logic [WORD_WIDTH-1:0] rd_b;

    // shared unit
    alu_cmd_t              alu_cmd;
    logic                  alu_done;
    logic [WORD_WIDTH-1:0] alu_result;

    // character decode
    logic [7:0]            digit8;
    logic                  is_digit;
    logic                  is_op;
    logic                  push_en;
    logic [WORD_WIDTH-1:0] push_val;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign digit8   = expr.character - CHR_ZERO;
    assign is_digit = (expr.character >= CHR_ZERO) && (expr.character <= CHR_NINE);
    assign is_op    = (expr.character == CHR_PLUS) || (expr.character == CHR_MINUS)
                   || (expr.character == CHR_STAR) || (expr.character == CHR_SLASH)
                   || (expr.character == CHR_CARET);

    pee_stack #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_stack (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (count_m1[AW-1:0]),
        .rd_addr_b (count_m2[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    pee_alu #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .lhs    (rd_b),
        .rhs    (rd_a),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = WORD_WIDTH'(digit8[3:0]);
        alu_cmd         = '0;
        push_en         = 1'b0;
        push_val        = alu_result;

        case (state_reg)
            S_IDLE:
            begin
                if (expr.valid)
                begin
                    op_next   = expr.character;
                    last_next = expr.end_of_expression;
                    if (is_digit)
                    begin
                        // push the digit now; a full stack drops it and flags overflow
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (expr.end_of_expression)
                        begin
                            state_next = S_RDTOP;
                        end
                    end
                    else if (count_reg < CW'(2))
                    begin
                        // too few operands wins over a bad character
                        res_value_next  = '0;
                        res_status_next = ST_UNDER;
                        state_next      = S_EMIT;
                    end
                    else if (!is_op)
                    begin
                        res_value_next  = '0;
                        res_status_next = ST_INVALID;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        // both operands are read at this edge
                        count_next = count_m2;
                        state_next = S_OPER;
                    end
                end
            end
            S_RDTOP:
            begin
                state_next = S_TOPWAIT;
            end
            S_TOPWAIT:
            begin
                res_value_next  = rd_a;
                res_status_next = ovf_reg ? ST_OVER : ST_OK;
                state_next      = S_EMIT;
            end
            S_OPER:
            begin
                // rd_a holds the right operand, rd_b the left one
                case (op_reg)
                    CHR_PLUS:
                    begin
                        push_en  = 1'b1;
                        push_val = rd_b + rd_a;
                    end
                    CHR_MINUS:
                    begin
                        push_en  = 1'b1;
                        push_val = rd_b - rd_a;
                    end
                    CHR_STAR:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_MUL;
                        state_next    = S_ALU;
                    end
                    CHR_SLASH:
                    begin
                        if (rd_a == '0)
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_DIVZERO;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = ALU_DIV;
                            state_next    = S_ALU;
                        end
                    end
                    CHR_CARET:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = ALU_POW;
                        state_next    = S_ALU;
                    end
                    default:
                    begin
                        res_value_next  = '0;
                        res_status_next = ST_INVALID;
                        state_next      = S_EMIT;
                    end
                endcase
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    push_en  = 1'b1;
                    push_val = alu_result;
                end
            end
            S_EMIT:
            begin
                // load the output register once it is free, then clear the stack
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = 32'(res_value_reg);
                    out_status_next = res_status_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // operator result push; two words were just popped so there is room
        if (push_en)
        begin
            wr_en      = 1'b1;
            wr_data    = push_val;
            count_next = count_reg + CW'(1);
            if (last_reg)
            begin
                res_value_next  = push_val;
                res_status_next = ovf_reg ? ST_OVER : ST_OK;
                state_next      = S_EMIT;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        last_reg       <= last_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign expr.ready   = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;
    assign result.status = out_status_reg;

    // stack count never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // the shared unit only finishes while the sequencer waits for it
    a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_ALU))
        else $error("arithmetic unit finished outside wait state");

    // after popping two operands the result push always has room
    a_oper_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OPER) |-> (count_reg <= CW'(STACK_DEPTH - 2)))
        else $error("operator push could overflow");

    // overflow flag is only raised by a push onto a full stack
    a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> ($past(count_reg) == CW'(STACK_DEPTH)))
        else $error("overflow flagged without a full stack");

endmodule

// ----- rtl/core/pee_stack.sv -----
// operand stack memory, one write port and two registered read ports
module pee_stack #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/core/pee_alu.sv -----
// shared iterative unit: digit-serial multiply, restoring divide, square-and-multiply power
module pee_alu
    import pee_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alu_cmd_t              cmd,
    input  logic [WORD_WIDTH-1:0] lhs,
    input  logic [WORD_WIDTH-1:0] rhs,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] result
);

    localparam int NDIG = (WORD_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW   = NDIG * MUL_DIGIT;
    localparam int PW   = WORD_WIDTH + MUL_DIGIT;
    localparam int CNW  = $clog2(WORD_WIDTH + 1);

    localparam logic [2:0] A_IDLE   = 3'd0;
    localparam logic [2:0] A_MUL    = 3'd1;
    localparam logic [2:0] A_DIV    = 3'd2;
    localparam logic [2:0] A_DIVFIX = 3'd3;
    localparam logic [2:0] A_PCHK   = 3'd4;
    localparam logic [2:0] A_PSQ    = 3'd5;

    // what a finished multiply feeds
    localparam logic [1:0] CTX_PROD = 2'd0;
    localparam logic [1:0] CTX_ACC  = 2'd1;
    localparam logic [1:0] CTX_SQ   = 2'd2;

    logic [2:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [1:0]            ctx_reg, ctx_next;
    logic [CNW-1:0]        cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] mul_a_reg, mul_a_next;
    logic [BW-1:0]         mul_b_reg, mul_b_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] pacc_reg, pacc_next;
    logic [WORD_WIDTH-1:0] base_reg, base_next;
    logic [WORD_WIDTH-1:0] exp_reg, exp_next;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [WORD_WIDTH-1:0] result_reg, result_next;

    logic [PW-1:0]         prod;
    logic [WORD_WIDTH-1:0] mul_sum;
    logic [WORD_WIDTH:0]   rem_sh;
    logic [WORD_WIDTH:0]   rem_diff;

    assign prod     = PW'(mul_a_reg) * PW'(mul_b_reg[MUL_DIGIT-1:0]);
    assign mul_sum  = acc_reg + prod[WORD_WIDTH-1:0];
    assign rem_sh   = {rem_reg, exp_reg[WORD_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, base_reg};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ctx_next    = ctx_reg;
        cnt_next    = cnt_reg;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        acc_next    = acc_reg;
        pacc_next   = pacc_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (cmd.start)
                begin
                    cnt_next = '0;
                    case (cmd.op)
                        ALU_MUL:
                        begin
                            mul_a_next = lhs;
                            mul_b_next = BW'(rhs);
                            acc_next   = '0;
                            ctx_next   = CTX_PROD;
                            state_next = A_MUL;
                        end
                        ALU_DIV:
                        begin
                            neg_next   = lhs[WORD_WIDTH-1] ^ rhs[WORD_WIDTH-1];
                            exp_next   = lhs[WORD_WIDTH-1] ? ('0 - lhs) : lhs;
                            base_next  = rhs[WORD_WIDTH-1] ? ('0 - rhs) : rhs;
                            rem_next   = '0;
                            state_next = A_DIV;
                        end
                        ALU_POW:
                        begin
                            if (rhs[WORD_WIDTH-1])
                            begin
                                // negative exponent
                                result_next = WORD_WIDTH'(1);
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                pacc_next  = WORD_WIDTH'(1);
                                base_next  = lhs;
                                exp_next   = rhs;
                                state_next = A_PCHK;
                            end
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next   = mul_sum;
                mul_a_next = mul_a_reg << MUL_DIGIT;
                mul_b_next = mul_b_reg >> MUL_DIGIT;
                cnt_next   = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(NDIG - 1))
                begin
                    cnt_next = '0;
                    case (ctx_reg)
                        CTX_ACC:
                        begin
                            pacc_next  = mul_sum;
                            state_next = A_PSQ;
                        end
                        CTX_SQ:
                        begin
                            base_next  = mul_sum;
                            exp_next   = exp_reg >> 1;
                            state_next = A_PCHK;
                        end
                        default:
                        begin
                            result_next = mul_sum;
                            done_next   = 1'b1;
                            state_next  = A_IDLE;
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                if (!rem_diff[WORD_WIDTH])
                begin
                    rem_next = rem_diff[WORD_WIDTH-1:0];
                end
                else
                begin
                    rem_next = rem_sh[WORD_WIDTH-1:0];
                end
                exp_next = {exp_reg[WORD_WIDTH-2:0], ~rem_diff[WORD_WIDTH]};
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(WORD_WIDTH - 1))
                begin
                    state_next = A_DIVFIX;
                end
            end
            A_DIVFIX:
            begin
                result_next = neg_reg ? ('0 - exp_reg) : exp_reg;
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            A_PCHK:
            begin
                if (exp_reg == '0)
                begin
                    result_next = pacc_reg;
                    done_next   = 1'b1;
                    state_next  = A_IDLE;
                end
                else if (exp_reg[0])
                begin
                    mul_a_next = pacc_reg;
                    mul_b_next = BW'(base_reg);
                    acc_next   = '0;
                    ctx_next   = CTX_ACC;
                    state_next = A_MUL;
                end
                else
                begin
                    state_next = A_PSQ;
                end
            end
            A_PSQ:
            begin
                // no square needed once the exponent runs out
                if ((exp_reg >> 1) == '0)
                begin
                    result_next = pacc_reg;
                    done_next   = 1'b1;
                    state_next  = A_IDLE;
                end
                else
                begin
                    mul_a_next = base_reg;
                    mul_b_next = BW'(base_reg);
                    acc_next   = '0;
                    ctx_next   = CTX_SQ;
                    state_next = A_MUL;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        cnt_reg    <= cnt_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        acc_reg    <= acc_next;
        pacc_reg   <= pacc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/postfix_expression_evaluator_tb.sv -----
// self-checking testbench for the postfix expression evaluator
module postfix_expression_evaluator_tb
    import pee_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 128;
    localparam int WORD_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 750;
    // power is the slowest operator
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;
    // long receiver hold that backs the block up into its input
    localparam int HOLD_AFTER   = 350;
    localparam int HOLD_CYCLES  = 600;

    // characters outside the digit and operator set
    localparam logic [7:0] CHR_NUL      = 8'h00;
    localparam logic [7:0] CHR_ALL_ONES = 8'hFF;

    typedef struct packed {
        bit [31:0] value;
        bit [2:0]  status;
    } rpn_result_t;

    // evaluates each accepted character and keeps the results still owed
    class rpn_scoreboard;
        bit [31:0]   operands [STACK_DEPTH];
        int unsigned depth;
        bit          overflow_seen;
        rpn_result_t expected_results [$];
        int unsigned errors;
        int unsigned accepted_chars;

        function new();
            depth          = 0;
            overflow_seen  = 1'b0;
            errors         = 0;
            accepted_chars = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns mismatch: %s", $time, msg);
        endtask

        function void stack_push(input bit [31:0] w);
            if (depth >= STACK_DEPTH)
                overflow_seen = 1'b1;
            else
            begin
                operands[depth] = w;
                depth++;
            end
        endfunction

        // every result clears the stack and the sticky overflow flag
        function void close_expression(input bit [31:0] v, input bit [2:0] st);
            rpn_result_t r;
            r.value  = v;
            r.status = st;
            expected_results.push_back(r);
            depth         = 0;
            overflow_seen = 1'b0;
        endfunction

        // signed division truncating toward zero, wraps for most negative / -1
        function bit [31:0] quotient(input bit [31:0] lhs, input bit [31:0] rhs);
            bit [31:0] mag_l;
            bit [31:0] mag_r;
            bit [31:0] q;
            mag_l = lhs[31] ? -lhs : lhs;
            mag_r = rhs[31] ? -rhs : rhs;
            q     = mag_l / mag_r;
            return (lhs[31] ^ rhs[31]) ? -q : q;
        endfunction

        // square and multiply, a negative exponent gives 1
        function bit [31:0] power(input bit [31:0] base, input bit [31:0] expo);
            bit [31:0] acc;
            acc = 32'd1;
            if (expo[31])
                return 32'd1;
            while (expo != 0)
            begin
                if (expo[0])
                    acc = acc * base;
                base = base * base;
                expo = expo >> 1;
            end
            return acc;
        endfunction

        function void take_char(input logic [7:0] ch, input logic last);
            bit [31:0] lhs;
            bit [31:0] rhs;
            bit [31:0] r;
            accepted_chars++;
            if (ch >= CHR_ZERO && ch <= CHR_NINE)
                stack_push(32'(ch - CHR_ZERO));
            else
            begin
                // underflow wins over an unknown character
                if (depth < 2)
                begin
                    close_expression(32'd0, ST_UNDER);
                    return;
                end
                rhs   = operands[depth - 1];
                lhs   = operands[depth - 2];
                depth = depth - 2;
                case (ch)
                    CHR_PLUS:  r = lhs + rhs;
                    CHR_MINUS: r = lhs - rhs;
                    CHR_STAR:  r = lhs * rhs;
                    CHR_SLASH:
                    begin
                        if (rhs == 0)
                        begin
                            close_expression(32'd0, ST_DIVZERO);
                            return;
                        end
                        r = quotient(lhs, rhs);
                    end
                    CHR_CARET: r = power(lhs, rhs);
                    default:
                    begin
                        close_expression(32'd0, ST_INVALID);
                        return;
                    end
                endcase
                stack_push(r);
            end
            if (last)
            begin
                if (depth == 0)
                    close_expression(32'd0, ST_UNDER);
                else
                    close_expression(operands[depth - 1], overflow_seen ? ST_OVER : ST_OK);
            end
        endfunction

        task check_result(input logic [31:0] v, input logic [2:0] st);
            rpn_result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %0d status %0d with nothing outstanding",
                                 $signed(v), st));
                return;
            end
            want = expected_results.pop_front();
            if (v !== want.value)
                report($sformatf("value got %0d expected %0d",
                                 $signed(v), $signed(want.value)));
            if (st !== want.status)
                report($sformatf("status got %0d expected %0d", st, want.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pee_in_if  expr_if ();
    pee_out_if result_if ();

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .expr  (expr_if),
        .result(result_if)
    );

    rpn_scoreboard sb;

    // sender pacing
    int unsigned burst_left;

    // expression generator state
    bit          expr_open;
    int unsigned steps_left;
    bit          deep_due;
    bit          deep_fill;
    bit          deep_tail;
    int unsigned deep_extra;

    int unsigned cycles = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, counts every cycle of the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // both channels are observed at the rising edge; the input item is
    // evaluated first so a same-edge result always finds its expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (expr_if.valid && expr_if.ready)
                sb.take_char(expr_if.character, expr_if.end_of_expression);
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.value, result_if.status);
        end
    end

    // offer one item; bursts of random length with random gaps between them,
    // some gaps are zero so back-to-back stretches also occur
    task automatic offer(input logic [7:0] ch, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                expr_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        expr_if.valid             <= 1'b1;
        expr_if.character         <= ch;
        expr_if.end_of_expression <= last;
        do
            @(posedge clk);
        while (!expr_if.ready);
        @(negedge clk);
    endtask

    // a text whose last character closes the expression
    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHR_PLUS;
            3, 4:    return CHR_MINUS;
            5, 6:    return CHR_STAR;
            7, 8:    return CHR_SLASH;
            default: return CHR_CARET;
        endcase
    endfunction

    // picks the next character from the live stack depth, so most expressions
    // are well formed; a few items are noise or operators on a short stack
    task automatic next_item(output logic [7:0] ch, output logic last);
        int unsigned d;
        int unsigned new_d;
        bit          use_op;
        d    = sb.depth;
        last = 1'b0;
        if (!expr_open)
        begin
            expr_open = 1'b1;
            if (deep_due)
            begin
                // fill the stack, push a few more that get dropped, then close
                deep_due   = 1'b0;
                deep_fill  = 1'b1;
                deep_extra = $urandom_range(1, 4);
                steps_left = $urandom_range(3, 6);
            end
            else
                steps_left = $urandom_range(1, 14);
        end
        if (deep_fill)
        begin
            ch = CHR_ZERO + 8'($urandom_range(0, 9));
            if (d >= STACK_DEPTH)
            begin
                if (deep_extra == 0)
                begin
                    deep_fill = 1'b0;
                    deep_tail = 1'b1;
                end
                else
                    deep_extra--;
            end
            return;
        end
        if ($urandom_range(0, 99) < 7)
        begin
            // noise: any byte, or an operator regardless of depth
            ch   = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : random_operator();
            last = ($urandom_range(0, 3) == 0);
            if (last)
            begin
                expr_open = 1'b0;
                deep_tail = 1'b0;
            end
            return;
        end
        use_op = (d >= 2) && (steps_left == 0 || deep_tail || $urandom_range(0, 2) == 0);
        if (use_op)
        begin
            ch    = random_operator();
            new_d = d - 1;
        end
        else
        begin
            ch    = CHR_ZERO + 8'($urandom_range(0, 9));
            new_d = (d < STACK_DEPTH) ? d + 1 : d;
        end
        if (steps_left > 0)
            steps_left--;
        // close once reduced to one word; sometimes leave words behind
        if (steps_left == 0 && (new_d <= 1 || deep_tail || $urandom_range(0, 9) == 0))
        begin
            last      = 1'b1;
            expr_open = 1'b0;
            deep_tail = 1'b0;
        end
    endtask

    // receiver: stretches of always-ready, random and mostly-stalled, plus
    // one long hold once enough input has gone in
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        bit          held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                if (!held && sb.accepted_chars >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    result_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                else
                    case (mode)
                        0:       result_if.ready <= 1'b1;
                        1:       result_if.ready <= 1'($urandom_range(0, 1));
                        default: result_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
            end
        end
    end

    // main sequence
    initial
    begin
        logic [7:0]  ch;
        logic        last;
        int unsigned random_sent;

        rst_n                       = 1'b0;
        expr_if.valid               = 1'b0;
        expr_if.character           = CHR_NUL;
        expr_if.end_of_expression   = 1'b0;
        result_if.ready             = 1'b0;
        sb                          = new();
        burst_left                  = 0;
        expr_open                   = 1'b0;
        steps_left                  = 0;
        deep_due                    = 1'b0;
        deep_fill                   = 1'b0;
        deep_tail                   = 1'b0;
        deep_extra                  = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: add and subtract
        offer_text("99+7-");
        // 2^31 is the most negative word; divided by -1 it wraps to itself
        offer_text("248*1-^01-/");
        // division by zero
        offer_text("50/");
        // unknown character with two words stacked, all-ones byte
        offer("1", 1'b0);
        offer("2", 1'b0);
        offer(CHR_ALL_ONES, 1'b0);
        // unknown character on an empty stack reports underflow
        offer(CHR_NUL, 1'b1);
        // negative exponent
        offer_text("201-^");

        // random expressions, two of them deep enough to overflow the stack
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent == 250 || random_sent == 550)
                deep_due = 1'b1;
            next_item(ch, last);
            offer(ch, last);
            random_sent++;
        end
        expr_if.valid <= 1'b0;

        // drain, then allow for a slow operator still in flight
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pee_pkg.sv
rtl/core/pee_ifs.sv
rtl/core/pee_stack.sv
rtl/core/pee_alu.sv
rtl/core/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_tb.sv
